// File: sv/qgnn_pkg.sv
// ----------------------------------------------------------------------------
// qgnn_pkg
// shared widths, register indexes and types for the quad grid node numbering
// ----------------------------------------------------------------------------
`default_nettype none

package qgnn_pkg;

    localparam int MAX_ACROSS = 256;
    localparam int MAX_DOWN   = 256;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 8;
    localparam int ELEM_W = 16;
    localparam int NODE_W = 17;
    localparam int REG_W  = 9;
    localparam int LINE_W = 2 * NODE_W;
    localparam int ADDR_W = (MAX_ACROSS > 1) ? $clog2(MAX_ACROSS) : 1;

    localparam int OUT_BITS = COL_W + ROW_W + ELEM_W + 4 * NODE_W;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_DW    = 8;

    localparam logic [REG_W-1:0] ACROSS_CAP = REG_W'(MAX_ACROSS);
    localparam logic [REG_W-1:0] DOWN_CAP   = REG_W'(MAX_DOWN);

    typedef enum logic [0:0] {
        REG_ELEMENTS_ACROSS = 1'b0,
        REG_ELEMENTS_DOWN   = 1'b1
    } reg_idx_t;

    // one numbered element, bottom corners may still come from the line store
    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [ELEM_W-1:0] element_number;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_c;
        logic [NODE_W-1:0] node_d;
        logic              last_element;
        logic              use_below;
    } elem_t;

    function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] raw,
                                                    input logic [REG_W-1:0] cap);
        logic [REG_W-1:0] res;
        begin
            res = raw;
            if (raw == '0) begin
                res = REG_W'(1);
            end else if (raw > cap) begin
                res = cap;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/qgnn_ram.sv
// ----------------------------------------------------------------------------
// qgnn_ram
// generic single-port-write, single-port-read ram, read-first, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module qgnn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: sv/qgnn_walker.sv
// ----------------------------------------------------------------------------
// qgnn_walker
// raster walk counters, node allocation and line store write side
// ----------------------------------------------------------------------------
`default_nettype none

module qgnn_walker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [0:0]                   cfg_addr,
    input  wire logic [qgnn_pkg::REG_W-1:0]   cfg_wdata,
    input  wire logic                         step,
    input  wire logic                         start_over,
    output qgnn_pkg::elem_t                   item,
    output logic                              line_we,
    output logic [qgnn_pkg::ADDR_W-1:0]       line_addr,
    output logic [qgnn_pkg::LINE_W-1:0]       line_wdata
);

    localparam int NW = qgnn_pkg::NODE_W;

    logic [qgnn_pkg::REG_W-1:0]  across_reg, down_reg;
    logic [qgnn_pkg::COL_W-1:0]  col_reg, col_next;
    logic [qgnn_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [qgnn_pkg::ELEM_W-1:0] elem_reg, elem_next;
    logic [NW-1:0]               nf_reg, nf_next;
    logic [NW-1:0]               lbr_reg, lbr_next;
    logic [NW-1:0]               ltr_reg, ltr_next;

    logic [qgnn_pkg::COL_W-1:0]  col;
    logic [qgnn_pkg::ROW_W-1:0]  row;
    logic [qgnn_pkg::ELEM_W-1:0] elem;
    logic [NW-1:0]               nf, a, b, c, d;
    logic [2:0]                  nf_inc;
    logic                        row0, col0, row_end, last;
    logic [qgnn_pkg::REG_W-1:0]  across_m1, down_m1;

    always_comb begin
        col  = start_over ? '0 : col_reg;
        row  = start_over ? '0 : row_reg;
        nf   = start_over ? '0 : nf_reg;
        elem = start_over ? '0 : elem_reg;
        row0 = (row == '0);
        col0 = (col == '0);

        a = '0;
        b = '0;
        if (row0 && col0) begin
            a = nf;
            b = nf + NW'(1);
            c = nf + NW'(2);
            d = nf + NW'(3);
            nf_inc = 3'd4;
        end else if (row0) begin
            a = lbr_reg;
            b = nf;
            c = nf + NW'(1);
            d = ltr_reg;
            nf_inc = 3'd2;
        end else if (col0) begin
            c = nf;
            d = nf + NW'(1);
            nf_inc = 3'd2;
        end else begin
            c = nf;
            d = ltr_reg;
            nf_inc = 3'd1;
        end

        across_m1 = qgnn_pkg::clamp_size(across_reg, qgnn_pkg::ACROSS_CAP)
                    - qgnn_pkg::REG_W'(1);
        down_m1   = qgnn_pkg::clamp_size(down_reg, qgnn_pkg::DOWN_CAP)
                    - qgnn_pkg::REG_W'(1);
        row_end = ({1'b0, col} >= across_m1);
        last    = row_end && ({1'b0, row} >= down_m1);

        lbr_next = row0 ? b : lbr_reg;
        ltr_next = c;
        if (last) begin
            col_next  = '0;
            row_next  = '0;
            nf_next   = '0;
            elem_next = '0;
        end else begin
            nf_next   = nf + NW'(nf_inc);
            elem_next = elem + qgnn_pkg::ELEM_W'(1);
            col_next  = row_end ? '0 : col + qgnn_pkg::COL_W'(1);
            row_next  = row_end ? row + qgnn_pkg::ROW_W'(1) : row;
        end
    end

    always_comb begin
        item.column         = col;
        item.row            = row;
        item.element_number = elem;
        item.node_a         = a;
        item.node_b         = b;
        item.node_c         = c;
        item.node_d         = d;
        item.last_element   = last;
        item.use_below      = !row0;
        line_we    = step;
        line_addr  = col[qgnn_pkg::ADDR_W-1:0];
        line_wdata = {c, d};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            across_reg <= qgnn_pkg::REG_W'(1);
            down_reg   <= qgnn_pkg::REG_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            elem_reg   <= '0;
            nf_reg     <= '0;
            lbr_reg    <= '0;
            ltr_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    qgnn_pkg::REG_ELEMENTS_ACROSS: across_reg <= cfg_wdata;
                    qgnn_pkg::REG_ELEMENTS_DOWN:   down_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (step) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                elem_reg <= elem_next;
                nf_reg   <= nf_next;
                lbr_reg  <= lbr_next;
                ltr_reg  <= ltr_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/quad_grid_node_numbering.sv
// ----------------------------------------------------------------------------
// quad_grid_node_numbering
// numbers elements and corner nodes of a structured quad grid, one per word
//
//   channel   direction  contents
//   s_*       in         tdata[0] start_over
//   m_*       out        tdata: column, row, element_number, a, b, c, d; tlast
//   cfg_*     in         register writes, index 0 across, 1 down
//
// one element per cycle sustained while m_tready holds; an accepted element passes
// through a read stage for the line store's registered read, then the output
// register, before m_tvalid rises
// the line store reads and writes the same column in the same cycle, read-first
// reset clears counters and handshake state; the line store is not cleared
// a stalled output holds the read stage, and the input stalls behind it
// ----------------------------------------------------------------------------
`default_nettype none

module quad_grid_node_numbering (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [qgnn_pkg::IN_DW-1:0]    s_tdata,   // [0] start_over
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // column, row, element_number, bottom_left, bottom_right, top_right, top_left
    output logic [qgnn_pkg::OUT_DW-1:0]        m_tdata,
    output logic                               m_tlast,   // last_element
    input  wire logic                          cfg_wr_en,
    input  wire logic [0:0]                    cfg_addr,
    input  wire logic [qgnn_pkg::REG_W-1:0]    cfg_wdata
);

    localparam int NW = qgnn_pkg::NODE_W;

    qgnn_pkg::elem_t               item, s1_reg;
    logic                          s1_valid_reg;
    logic                          m_valid_reg;
    logic [qgnn_pkg::OUT_DW-1:0]   m_data_reg;
    logic                          m_last_reg;
    logic                          accept, advance;
    logic                          line_we;
    logic [qgnn_pkg::ADDR_W-1:0]   line_addr;
    logic [qgnn_pkg::LINE_W-1:0]   line_wdata, line_rdata;
    logic [NW-1:0]                 a_fin, b_fin;

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    qgnn_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .step       (accept),
        .start_over (s_tdata[0]),
        .item       (item),
        .line_we    (line_we),
        .line_addr  (line_addr),
        .line_wdata (line_wdata)
    );

    qgnn_ram #(
        .WIDTH (qgnn_pkg::LINE_W),
        .DEPTH (qgnn_pkg::MAX_ACROSS)
    ) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_addr),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (line_addr),
        .rdata (line_rdata)
    );

    // line word holds c in the upper half and d in the lower half
    assign a_fin = s1_reg.use_below ? line_rdata[NW-1:0]      : s1_reg.node_a;
    assign b_fin = s1_reg.use_below ? line_rdata[2*NW-1:NW]   : s1_reg.node_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            s1_reg <= item;
        end
        if (advance) begin
            m_data_reg <= qgnn_pkg::OUT_DW'({s1_reg.node_d, s1_reg.node_c, b_fin, a_fin,
                                             s1_reg.element_number, s1_reg.row,
                                             s1_reg.column});
            m_last_reg <= s1_reg.last_element;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_quad_grid_node_numbering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_grid_node_numbering
// self-checking bench for the quad grid node numbering block: a directed
// table of words and grid sizes, a full-width and a full-height phase, then
// random phases of restarts and register settings, each result checked against
// an in-bench model of the numbering walk or a pinned table entry, with random
// gaps on both streams and one long output hold-off
module tb_quad_grid_node_numbering;
    import qgnn_pkg::*;

    // m_tdata field offsets, lowest first
    localparam int ROW_LO  = COL_W;
    localparam int ELEM_LO = ROW_LO + ROW_W;
    localparam int A_LO    = ELEM_LO + ELEM_W;
    localparam int B_LO    = A_LO + NODE_W;
    localparam int C_LO    = B_LO + NODE_W;
    localparam int D_LO    = C_LO + NODE_W;

    localparam int ITEM_TARGET = 1700;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 200;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [ELEM_W-1:0] element_number;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_c;
        logic [NODE_W-1:0] node_d;
        logic              last_element;
    } grid_elem_t;

    typedef struct packed {
        logic             is_write;
        reg_idx_t         reg_sel;
        logic [REG_W-1:0] value;
        logic             start_over;
        logic             pinned;
        grid_elem_t       result;
    } walk_step_t;

    // first element of a walk: four fresh corners
    localparam grid_elem_t FIRST_ONLY = '{8'd0, 8'd0, 16'd0, 17'd0, 17'd1, 17'd2, 17'd3, 1'b1};
    localparam grid_elem_t FIRST_OPEN = '{8'd0, 8'd0, 16'd0, 17'd0, 17'd1, 17'd2, 17'd3, 1'b0};
    localparam grid_elem_t NONE       = '0;

    localparam int N_DIRECTED = 22;
    localparam walk_step_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b1, FIRST_ONLY}, // 1 x 1 grid after reset
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b1, 1'b1, FIRST_ONLY},
        '{1'b1, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},       // zero acts as one
        '{1'b1, REG_ELEMENTS_DOWN,   9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b1, FIRST_ONLY},
        '{1'b1, REG_ELEMENTS_ACROSS, 9'd511, 1'b0, 1'b0, NONE},       // saturates
        '{1'b1, REG_ELEMENTS_DOWN,   9'd3,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b1, FIRST_OPEN},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b1, 1'b1, FIRST_OPEN}, // restart mid-row
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b1, REG_ELEMENTS_ACROSS, 9'd2,   1'b0, 1'b0, NONE},       // column now past the end
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b1, FIRST_OPEN}, // wrapped to a new walk
        '{1'b1, REG_ELEMENTS_ACROSS, 9'd1,   1'b0, 1'b0, NONE},
        '{1'b1, REG_ELEMENTS_DOWN,   9'd2,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE},
        '{1'b0, REG_ELEMENTS_ACROSS, 9'd0,   1'b0, 1'b0, NONE}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;
    logic                m_tlast;
    logic                cfg_wr_en;
    logic [0:0]          cfg_addr;
    logic [REG_W-1:0]    cfg_wdata;

    quad_grid_node_numbering dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // numbering model state
    logic [REG_W-1:0]  across_reg = REG_W'(1);
    logic [REG_W-1:0]  down_reg   = REG_W'(1);
    logic [NODE_W-1:0] free_node  = '0;
    logic [COL_W-1:0]  col_ctr    = '0;
    logic [ROW_W-1:0]  row_ctr    = '0;
    logic [ELEM_W-1:0] elem_ctr   = '0;
    logic [NODE_W-1:0] left_b     = '0;
    logic [NODE_W-1:0] left_c     = '0;
    logic [LINE_W-1:0] top_line [MAX_ACROSS];
    int                cols_written = 0;

    grid_elem_t        pending_q [$];
    bit                pinned = 1'b0;
    grid_elem_t        pinned_res = '0;
    bit                must_restart = 1'b0;
    bit                tx_steady = 1'b0;
    bit                rx_steady = 1'b0;
    bit                hold_done = 1'b0;

    int errors = 0;
    int checked = 0;
    int accepted = 0;
    int walks = 0;
    int restarts = 0;
    int writes = 0;
    int idle_cycles = 0;
    int widest = 1;
    int tallest = 1;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int legal_size(input logic [REG_W-1:0] raw, input int cap);
        if (raw == '0) return 1;
        if (int'(raw) > cap) return cap;
        return int'(raw);
    endfunction

    // numbers one element and advances the walk
    function automatic grid_elem_t number_element(input logic restart);
        grid_elem_t        res;
        logic [NODE_W-1:0] a, b, c, d, nf;
        logic [LINE_W-1:0] below;
        int                across_n, down_n, col, row;
        bit                row_end;
        across_n = legal_size(across_reg, MAX_ACROSS);
        down_n   = legal_size(down_reg, MAX_DOWN);
        if (across_n > widest) widest = across_n;
        if (down_n > tallest) tallest = down_n;
        if (restart) begin
            free_node = '0;
            col_ctr   = '0;
            row_ctr   = '0;
            elem_ctr  = '0;
        end
        col = int'(col_ctr);
        row = int'(row_ctr);
        nf  = free_node;
        if (row == 0) begin
            if (col == 0) begin
                a  = nf;
                b  = nf + NODE_W'(1);
                c  = nf + NODE_W'(2);
                d  = nf + NODE_W'(3);
                nf = nf + NODE_W'(4);
            end else begin
                a  = left_b;
                b  = nf;
                c  = nf + NODE_W'(1);
                d  = left_c;
                nf = nf + NODE_W'(2);
            end
        end else begin
            // bottom corners are the top corners of the element below
            below = top_line[col_ctr];
            a = below[NODE_W-1:0];
            b = below[LINE_W-1:NODE_W];
            c = nf;
            if (col == 0) begin
                d  = nf + NODE_W'(1);
                nf = nf + NODE_W'(2);
            end else begin
                d  = left_c;
                nf = nf + NODE_W'(1);
            end
        end
        top_line[col_ctr] = {c, d};
        left_b = b;
        left_c = c;
        if (col >= cols_written) cols_written = col + 1;

        row_end = (col >= across_n - 1);
        res.column         = col_ctr;
        res.row            = row_ctr;
        res.element_number = elem_ctr;
        res.node_a         = a;
        res.node_b         = b;
        res.node_c         = c;
        res.node_d         = d;
        res.last_element   = row_end && (row >= down_n - 1);

        if (res.last_element) begin
            free_node = '0;
            col_ctr   = '0;
            row_ctr   = '0;
            elem_ctr  = '0;
        end else begin
            free_node = nf;
            elem_ctr  = elem_ctr + ELEM_W'(1);
            if (row_end) begin
                col_ctr = '0;
                row_ctr = row_ctr + ROW_W'(1);
            end else begin
                col_ctr = col_ctr + COL_W'(1);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: element %0d %s: got %0d, expected %0d", $time, checked, what, got, want);
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // monitor: checks results, feeds the model, counts idle cycles
    always @(posedge aclk) begin
        grid_elem_t got, want;
        bit         moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got.column         = m_tdata[0 +: COL_W];
                got.row            = m_tdata[ROW_LO +: ROW_W];
                got.element_number = m_tdata[ELEM_LO +: ELEM_W];
                got.node_a         = m_tdata[A_LO +: NODE_W];
                got.node_b         = m_tdata[B_LO +: NODE_W];
                got.node_c         = m_tdata[C_LO +: NODE_W];
                got.node_d         = m_tdata[D_LO +: NODE_W];
                got.last_element   = m_tlast;
                if (pending_q.size() == 0) begin
                    report_mismatch("word with nothing expected",
                                    longint'(got.element_number), longint'(-1));
                end else begin
                    want = pending_q.pop_front();
                    if (got.column !== want.column)
                        report_mismatch("column", longint'(got.column),
                                        longint'(want.column));
                    if (got.row !== want.row)
                        report_mismatch("row", longint'(got.row), longint'(want.row));
                    if (got.element_number !== want.element_number)
                        report_mismatch("element_number", longint'(got.element_number),
                                        longint'(want.element_number));
                    if (got.node_a !== want.node_a)
                        report_mismatch("bottom_left", longint'(got.node_a),
                                        longint'(want.node_a));
                    if (got.node_b !== want.node_b)
                        report_mismatch("bottom_right", longint'(got.node_b),
                                        longint'(want.node_b));
                    if (got.node_c !== want.node_c)
                        report_mismatch("top_right", longint'(got.node_c),
                                        longint'(want.node_c));
                    if (got.node_d !== want.node_d)
                        report_mismatch("top_left", longint'(got.node_d),
                                        longint'(want.node_d));
                    if (got.last_element !== want.last_element)
                        report_mismatch("last_element", longint'(got.last_element),
                                        longint'(want.last_element));
                end
                checked++;
                if (got.last_element === 1'b1) walks++;
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                want = number_element(s_tdata[0]);
                if (pinned) want = pinned_res;
                pending_q.push_back(want);
                accepted++;
                if (s_tdata[0]) restarts++;
            end
            if (cfg_wr_en) begin
                if (reg_idx_t'(cfg_addr) == REG_ELEMENTS_ACROSS) across_reg = cfg_wdata;
                else down_reg = cfg_wdata;
                writes++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a word moving", IDLE_LIMIT);
                $display("tb_quad_grid_node_numbering: FAIL");
                $finish;
            end
        end
    end

    // result side: random back-pressure and one long hold-off
    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && s_tvalid && accepted >= 500) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 5) == 0) stall = gap_length();
            end
            if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
        end
    end

    // entered right after an accept edge; returns on the edge that accepts this word
    task automatic push_element(input logic start_over, input bit pin, input grid_elem_t res);
        int gap;
        gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : gap_length();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        pinned     = pin;
        pinned_res = res;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DW'(start_over | must_restart);
        must_restart = 1'b0;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
    endtask

    task automatic set_register(input reg_idx_t idx, input logic [REG_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        // a wider grid mid-walk would read line entries never written
        if (row_ctr != '0 && legal_size(across_reg, MAX_ACROSS) > cols_written)
            must_restart = 1'b1;
    endtask

    task automatic run_phase(input logic [REG_W-1:0] across_raw,
                             input logic [REG_W-1:0] down_raw,
                             input int count, input int restart_odds);
        set_register(REG_ELEMENTS_ACROSS, across_raw);
        set_register(REG_ELEMENTS_DOWN, down_raw);
        tx_steady = ($urandom_range(0, 3) == 0);
        repeat (count)
            push_element(restart_odds > 0 && $urandom_range(1, restart_odds) == 1, 1'b0, NONE);
    endtask

    function automatic logic [REG_W-1:0] random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return REG_W'($urandom_range(257, 511));
        if (r < 22) return REG_W'(256);
        return REG_W'($urandom_range(1, 12));
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].is_write)
                set_register(DIRECTED[i].reg_sel, DIRECTED[i].value);
            else
                push_element(DIRECTED[i].start_over, DIRECTED[i].pinned, DIRECTED[i].result);
        end

        // one full-width row and one full-height column
        run_phase(REG_W'(511), REG_W'(0), 260, 0);
        run_phase(REG_W'(0), REG_W'(511), 260, 0);
        while (accepted < ITEM_TARGET)
            run_phase(random_size(), random_size(), $urandom_range(30, 120), 40);

        drain_results();
        repeat (10) @(posedge aclk);

        $display("numbered %0d elements over %0d finished walks, %0d restarts, %0d writes",
                 checked, walks, restarts, writes);
        $display("grid sizes reached %0d across and %0d down; output held off %0d cycles once",
                 widest, tallest, HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb_quad_grid_node_numbering: PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_quad_grid_node_numbering: FAIL");
        end
        $finish;
    end

endmodule
